>>> src/olist_pkg.sv
// Shared types and codes for the ordered list engine.
// No dependencies; used by olist_cell and ordered_list_engine.
package olist_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [2:0] KIND_INSERT    = 3'd0;
   localparam logic [2:0] KIND_RM_LAST   = 3'd1;
   localparam logic [2:0] KIND_RM_FIRST  = 3'd2;
   localparam logic [2:0] KIND_RM_AT     = 3'd3;
   localparam logic [2:0] KIND_FIND      = 3'd4;
   localparam logic [2:0] KIND_READ      = 3'd5;

   // Status codes carried in the response tuser field.
   localparam logic [2:0] STAT_OK          = 3'd0;
   localparam logic [2:0] STAT_FULL        = 3'd1;
   localparam logic [2:0] STAT_UNREACHABLE = 3'd2;
   localparam logic [2:0] STAT_EMPTY       = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND   = 3'd4;

   localparam logic [31:0] FAIL_ANSWER = 32'hFFFF_FFFF;

   // Number of match bits examined per cycle during a search.
   localparam int SCAN_CHUNK = 8;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic        ins;    // insert value at pos, later entries move up
      logic        rem;    // remove entry at pos, later entries move down
      logic [4:0]  pos;
      logic [31:0] value;  // insert data, also the search key
   } cmd_type;

endpackage

>>> src/olist_cell.sv
// One storage cell of the ordered list chain.
// Depends on olist_pkg for the broadcast command type.
module olist_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                 clock,
   input  olist_pkg::cmd_type   cmd,
   input  logic [CNT_W-1:0]     count,
   input  logic [31:0]          left_data,
   input  logic [31:0]          right_data,
   output logic [31:0]          data,
   output logic                 match
);

   localparam int CW = (CNT_W > 5) ? CNT_W : 5;

   logic [31:0]   data_ff;
   logic [31:0]   data_in;
   logic [CW-1:0] idx_c;
   logic [CW-1:0] pos_c;
   logic [CW-1:0] cnt_c;

   assign idx_c = CW'(IDX);
   assign pos_c = CW'(cmd.pos);
   assign cnt_c = CW'(count);

   // An insert opens a gap at pos by pulling from the left; a removal closes
   // it by pulling from the right.
   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (idx_c > pos_c) begin
            data_in = left_data;
         end else if (idx_c == pos_c) begin
            data_in = cmd.value;
         end
      end else if (cmd.rem) begin
         if (idx_c >= pos_c) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign match = (idx_c < cnt_c) && (data_ff == cmd.value);

endmodule

>>> src/ordered_list_engine.sv
// Top level of the ordered list engine: handshake, control and search scan.
// Depends on olist_pkg and instantiates a chain of olist_cell.

// The engine keeps an ordered list of up to CAPACITY signed 32-bit values in a
// chain of cells, one entry per cell, with position 0 at the front. Each
// request transaction carries an operation in req_tuser and a position and a
// value in req_tdata; each produces exactly one response transaction with a
// status in rsp_tuser and the answer and the entry count in rsp_tdata.
// Insert, the three removals and read sustain one transaction per cycle while
// the output register is free: an insert, remove-first or remove-at shifts
// every cell toward or away from its neighbor at the same time, and remove-last
// only lowers the count. A find compares the key in every cell in the cycle it
// is accepted, then scans the registered match bits eight positions per cycle
// and takes no new request until the scan stops at the first chunk that holds
// a match or as soon as no match bits remain. A response waits in an output
// register, and a new request is taken in the same cycle the waiting response
// leaves. Only positions 0 to 31 can be addressed, and the count field
// carries the low five bits of the held count. Entries are not cleared at
// reset; the count alone marks which are valid.
module ordered_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // kind
   input  logic [39:0] req_tdata,   // position[4:0], value[36:5], zero[39:37]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic [39:0] rsp_tdata    // answer[31:0], count[36:32], zero[39:37]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
   localparam int MW    = ((CAPACITY + olist_pkg::SCAN_CHUNK - 1) /
                           olist_pkg::SCAN_CHUNK) * olist_pkg::SCAN_CHUNK;
   localparam int BW    = $clog2(MW + 1);
   localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;
   localparam int PW    = $clog2(olist_pkg::SCAN_CHUNK);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   // Lowest set bit of one chunk of match bits.
   function automatic logic [PW-1:0] first_set(
      input logic [olist_pkg::SCAN_CHUNK-1:0] bits
   );
      logic [PW-1:0] idx;
      idx = '0;
      for (int i = olist_pkg::SCAN_CHUNK - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = PW'(i);
         end
      end
      return idx;
   endfunction

   logic                 state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MW-1:0]        match_ff, match_in;
   logic [BW-1:0]        base_ff, base_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_answer_ff, rsp_answer_in;
   logic [4:0]           rsp_count_ff, rsp_count_in;

   logic [2:0]           kind;
   logic [4:0]           pos;
   logic [31:0]          value;
   logic                 req_acc;
   logic                 out_free;
   logic                 rsp_load;
   olist_pkg::cmd_type   cmd;
   logic [31:0]          cell_data [CAPACITY];
   logic [CAPACITY-1:0]  cell_match;
   logic [MW-1:0]        match_vec;
   logic [CW-1:0]        pos_c;
   logic [CW-1:0]        cnt_c;
   logic [31:0]          rd_data;
   logic [olist_pkg::SCAN_CHUNK-1:0] chunk;
   logic                 hit;
   logic                 none_left;
   logic [2:0]           imm_status;
   logic [31:0]          imm_answer;

   assign kind  = req_tuser;
   assign pos   = req_tdata[4:0];
   assign value = req_tdata[36:5];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;

   assign pos_c = CW'(pos);
   assign cnt_c = CW'(cnt_ff);

   // The cell chain. Cell 0 has no left neighbor and the last cell no right
   // neighbor; both simply see their own data there.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [31:0] left_d;
      logic [31:0] right_d;
      if (g == 0) begin : g_first
         assign left_d = cell_data[g];
      end else begin : g_inner_l
         assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[g];
      end else begin : g_inner_r
         assign right_d = cell_data[g+1];
      end
      olist_cell #(
         .IDX   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (cnt_ff),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[g]),
         .match      (cell_match[g])
      );
   end

   // Read port over the addressable positions.
   always_comb begin
      rd_data = '0;
      for (int i = 0; i < RD_N; i++) begin
         if (pos == 5'(i)) begin
            rd_data = cell_data[i];
         end
      end
   end

   always_comb begin
      match_vec = '0;
      match_vec[CAPACITY-1:0] = cell_match;
   end

   // Decode of the operations that need no scan. The cell command is qualified by
   // the accept so that the chain only moves on a real transaction.
   always_comb begin
      cmd.ins    = 1'b0;
      cmd.rem    = 1'b0;
      cmd.pos    = pos;
      cmd.value  = value;
      cnt_in     = cnt_ff;
      imm_status = olist_pkg::STAT_OK;
      imm_answer = '0;
      unique case (kind)
         olist_pkg::KIND_INSERT: begin
            if (cnt_ff == CNT_W'(CAPACITY)) begin
               imm_status = olist_pkg::STAT_FULL;
            end else if (pos_c > cnt_c) begin
               imm_status = olist_pkg::STAT_UNREACHABLE;
            end else begin
               cmd.ins = req_acc;
               cnt_in  = req_acc ? cnt_ff + 1'b1 : cnt_ff;
            end
         end
         olist_pkg::KIND_RM_LAST: begin
            if (cnt_ff == '0) begin
               imm_status = olist_pkg::STAT_EMPTY;
            end else begin
               cnt_in = req_acc ? cnt_ff - 1'b1 : cnt_ff;
            end
         end
         olist_pkg::KIND_RM_FIRST: begin
            cmd.pos = '0;
            if (cnt_ff == '0) begin
               imm_status = olist_pkg::STAT_EMPTY;
            end else begin
               cmd.rem = req_acc;
               cnt_in  = req_acc ? cnt_ff - 1'b1 : cnt_ff;
            end
         end
         olist_pkg::KIND_RM_AT: begin
            if (cnt_ff == '0) begin
               imm_status = olist_pkg::STAT_EMPTY;
            end else if (pos_c >= cnt_c) begin
               imm_status = olist_pkg::STAT_UNREACHABLE;
            end else begin
               cmd.rem = req_acc;
               cnt_in  = req_acc ? cnt_ff - 1'b1 : cnt_ff;
            end
         end
         olist_pkg::KIND_READ: begin
            if (pos_c >= cnt_c) begin
               imm_status = olist_pkg::STAT_UNREACHABLE;
            end else begin
               imm_answer = rd_data;
            end
         end
         default: begin
            // Find is answered by the scan; unused kinds leave everything
            // unchanged and report success.
         end
      endcase
      if (imm_status != olist_pkg::STAT_OK) begin
         imm_answer = olist_pkg::FAIL_ANSWER;
      end
   end

   // Search scan: the lowest chunk of match bits is examined each cycle and
   // the vector moves down by one chunk when it holds no match.
   assign chunk     = match_ff[olist_pkg::SCAN_CHUNK-1:0];
   assign hit       = |chunk;
   assign none_left = ~|match_ff;

   always_comb begin
      state_in      = state_ff;
      match_in      = match_ff;
      base_in       = base_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (kind == olist_pkg::KIND_FIND) begin
                  state_in = ST_SCAN;
                  match_in = match_vec;
                  base_in  = '0;
               end else begin
                  rsp_load      = 1'b1;
                  rsp_status_in = imm_status;
                  rsp_answer_in = imm_answer;
                  rsp_count_in  = 5'(cnt_in);
               end
            end
         end
         ST_SCAN: begin
            if (hit || none_left) begin
               if (out_free) begin
                  state_in     = ST_IDLE;
                  rsp_load     = 1'b1;
                  rsp_count_in = 5'(cnt_ff);
                  if (hit) begin
                     rsp_status_in = olist_pkg::STAT_OK;
                     rsp_answer_in = 32'(base_ff) + 32'(first_set(chunk));
                  end else begin
                     rsp_status_in = olist_pkg::STAT_NOT_FOUND;
                     rsp_answer_in = olist_pkg::FAIL_ANSWER;
                  end
               end
            end else begin
               match_in = match_ff >> olist_pkg::SCAN_CHUNK;
               base_in  = base_ff + BW'(olist_pkg::SCAN_CHUNK);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff      <= match_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_answer_ff};

`ifndef ASSERT_OFF
   // The held count never goes past the capacity.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // The count moves only with an accepted transaction.
   a_cnt_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> $stable(cnt_ff))
      else $error("entry count changed without a request");

   // Every operation other than find answers in the following cycle.
   a_imm_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_acc && kind != olist_pkg::KIND_FIND) |=> rsp_valid_ff)
      else $error("single-cycle operation gave no response");

   // A find always moves the engine into the scan.
   a_find_scan: assert property (@(posedge clock) disable iff (reset)
      (req_acc && kind == olist_pkg::KIND_FIND) |=> state_ff == ST_SCAN)
      else $error("find did not start a scan");

   // The scan base never runs past the padded match vector.
   a_scan_base: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> base_ff < BW'(MW))
      else $error("scan base out of range");
`endif

endmodule
